FILE: src/lr_pkg.sv
// Line rasterizer package: default sizes, controller states and the
// command/status bundles exchanged between controller and datapath.
// No dependencies.
package lr_pkg;

   localparam int LR_COORD_BITS = 6;
   localparam int LR_COLOR_BITS = 24;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } lr_state_type;

   // Controller -> datapath commands
   typedef struct packed {
      logic load;    // capture the incoming line command
      logic setup;   // compute deltas, directions and initial error
      logic step;    // emit current pixel and advance one step
   } lr_cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic degenerate; // endpoints equal, no pixels
      logic last;       // current pixel is the final one of the run
      logic out_free;   // output register can take a pixel this cycle
   } lr_sts_type;

endpackage

FILE: src/lr_if.sv
// Valid/ready channel interfaces for line commands and pixel results.
// Depends on lr_pkg.
interface lr_req_if
   import lr_pkg::*;
#(
   parameter int COORD_BITS = LR_COORD_BITS
);
   logic                     valid;
   logic                     ready;
   logic [COORD_BITS-1:0]    x_start;
   logic [COORD_BITS-1:0]    y_start;
   logic [COORD_BITS-1:0]    x_end;
   logic [COORD_BITS-1:0]    y_end;
   logic [LR_COLOR_BITS-1:0] pixel_color;

   modport source (output valid, x_start, y_start, x_end, y_end, pixel_color,
                   input ready);
   modport sink   (input valid, x_start, y_start, x_end, y_end, pixel_color,
                   output ready);
endinterface

interface lr_rsp_if
   import lr_pkg::*;
#(
   parameter int COORD_BITS = LR_COORD_BITS
);
   logic                     valid;
   logic                     ready;
   logic [COORD_BITS-1:0]    pixel_x;
   logic [COORD_BITS-1:0]    pixel_y;
   logic [LR_COLOR_BITS-1:0] out_color;
   logic                     last_pixel;

   modport source (output valid, pixel_x, pixel_y, out_color, last_pixel,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, out_color, last_pixel,
                   output ready);
endinterface

FILE: src/lr_ctrl.sv
// Line rasterizer controller: sequences load, setup and pixel stepping.
// Depends on lr_pkg.
module lr_ctrl
   import lr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  lr_sts_type sts,
   output lr_cmd_type cmd
);

   lr_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = sts.degenerate ? ST_IDLE : ST_RUN;
         end
         ST_RUN: begin
            if (sts.out_free && sts.last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ST_RUN: begin
            cmd.step = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

FILE: src/lr_datapath.sv
// Line rasterizer datapath: coordinate and error registers, Bresenham step
// logic and the pixel output register. Depends on lr_pkg.
module lr_datapath
   import lr_pkg::*;
#(
   parameter int COORD_BITS = LR_COORD_BITS
)(
   input  logic                     clock,
   input  logic                     reset,
   input  lr_cmd_type               cmd,
   output lr_sts_type               sts,
   input  logic [COORD_BITS-1:0]    x_start,
   input  logic [COORD_BITS-1:0]    y_start,
   input  logic [COORD_BITS-1:0]    x_end,
   input  logic [COORD_BITS-1:0]    y_end,
   input  logic [LR_COLOR_BITS-1:0] pixel_color,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [COORD_BITS-1:0]    pixel_x,
   output logic [COORD_BITS-1:0]    pixel_y,
   output logic [LR_COLOR_BITS-1:0] out_color,
   output logic                     last_pixel
);

   localparam int CB = COORD_BITS;
   localparam int EW = COORD_BITS + 3;   // signed error term

   logic [CB-1:0]            x_ff, x_in, y_ff, y_in;
   logic [CB-1:0]            xe_ff, ye_ff;
   logic [LR_COLOR_BITS-1:0] color_ff;
   logic                     sx_neg_ff, sy_neg_ff, x_major_ff;
   logic [CB:0]              adx2_ff, ady2_ff;
   logic signed [EW-1:0]     err_ff, err_in;

   logic                     out_valid_ff, out_valid_in;
   logic [CB-1:0]            px_ff, py_ff;
   logic [LR_COLOR_BITS-1:0] pcolor_ff;
   logic                     plast_ff;

   // Setup terms from the captured endpoints
   logic [CB:0]   dx, dy, dx_neg, dy_neg;
   logic [CB-1:0] adx, ady;
   assign dx     = {1'b0, xe_ff} - {1'b0, x_ff};
   assign dy     = {1'b0, ye_ff} - {1'b0, y_ff};
   assign dx_neg = -dx;
   assign dy_neg = -dy;
   assign adx    = dx[CB] ? dx_neg[CB-1:0] : dx[CB-1:0];
   assign ady    = dy[CB] ? dy_neg[CB-1:0] : dy[CB-1:0];

   // One Bresenham step
   logic [CB-1:0]        x_step, y_step;
   logic [CB:0]          minor2, major2;
   logic signed [EW-1:0] err_sub;
   logic                 step_minor;
   assign x_step     = sx_neg_ff ? x_ff - CB'(1) : x_ff + CB'(1);
   assign y_step     = sy_neg_ff ? y_ff - CB'(1) : y_ff + CB'(1);
   assign minor2     = x_major_ff ? ady2_ff : adx2_ff;
   assign major2     = x_major_ff ? adx2_ff : ady2_ff;
   assign err_sub    = err_ff - $signed({2'b00, minor2});
   assign step_minor = err_sub[EW-1] || (err_sub == '0);

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      err_in = err_ff;
      if (cmd.load) begin
         x_in = x_start;
         y_in = y_start;
      end else if (cmd.setup) begin
         // error starts at the major delta
         err_in = (ady < adx) ? $signed({3'b000, adx}) : $signed({3'b000, ady});
      end else if (cmd.step) begin
         err_in = step_minor ? err_sub + $signed({2'b00, major2}) : err_sub;
         if (x_major_ff) begin
            x_in = x_step;
            if (step_minor) y_in = y_step;
         end else begin
            y_in = y_step;
            if (step_minor) x_in = x_step;
         end
      end
   end

   // Line state registers
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      err_ff <= err_in;
      if (cmd.load) begin
         xe_ff    <= x_end;
         ye_ff    <= y_end;
         color_ff <= pixel_color;
      end
      if (cmd.setup) begin
         sx_neg_ff  <= dx[CB];
         sy_neg_ff  <= dy[CB];
         x_major_ff <= (ady < adx);
         adx2_ff    <= {adx, 1'b0};
         ady2_ff    <= {ady, 1'b0};
      end
   end

   // Output register
   assign out_valid_in = cmd.step ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         px_ff     <= x_ff;
         py_ff     <= y_ff;
         pcolor_ff <= color_ff;
         plast_ff  <= sts.last;
      end
   end

   // Status
   assign sts.degenerate = (x_ff == xe_ff) && (y_ff == ye_ff);
   assign sts.last       = x_major_ff ? (x_step == xe_ff) : (y_step == ye_ff);
   assign sts.out_free   = !out_valid_ff || rsp_ready;

   assign rsp_valid  = out_valid_ff;
   assign pixel_x    = px_ff;
   assign pixel_y    = py_ff;
   assign out_color  = pcolor_ff;
   assign last_pixel = plast_ff;

endmodule

FILE: src/line_rasterizer_top.sv
// Line rasterizer top level: joins controller and datapath to the channels.
// Depends on lr_pkg, lr_if, lr_ctrl and lr_datapath.
//
// Usage:
//   req_ch carries one line command (start point, end point, color). It is
//   taken only while the block is idle; ready stays low from the transfer
//   until the last pixel of that line has been loaded into the output
//   register.
//   rsp_ch delivers one pixel per transfer, start point first, end point
//   left out, last_pixel set on the final pixel. Equal endpoints give no
//   pixels.
// Timing:
//   Command capture and setup come first, in the idle and setup states;
//   then one pixel per cycle while the receiver keeps ready high. A line
//   holds at most 2^COORD_BITS - 1 pixels. The first pixel is stepped
//   in the run state and offered from the output register. The single step
//   unit of the datapath sets the pixel rate.
//   A stalled receiver holds the output register; stepping pauses until the
//   pixel is taken. A new command may be taken while the last pixel waits.
// Reset:
//   Synchronous, active high; returns to idle and drops rsp valid.
module line_rasterizer_top
   import lr_pkg::*;
#(
   parameter int COORD_BITS = LR_COORD_BITS
)(
   input  logic  clock,
   input  logic  reset,
   lr_req_if.sink   req_ch,
   lr_rsp_if.source rsp_ch
);

   lr_cmd_type cmd;
   lr_sts_type sts;

   lr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lr_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .x_start     (req_ch.x_start),
      .y_start     (req_ch.y_start),
      .x_end       (req_ch.x_end),
      .y_end       (req_ch.y_end),
      .pixel_color (req_ch.pixel_color),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .pixel_x     (rsp_ch.pixel_x),
      .pixel_y     (rsp_ch.pixel_y),
      .out_color   (rsp_ch.out_color),
      .last_pixel  (rsp_ch.last_pixel)
   );

endmodule

FILE: src/lr_checker.sv
// Port-level checks for the line rasterizer, bound to the top level.
// Depends on lr_pkg and line_rasterizer_top.
module lr_checker
   import lr_pkg::*;
#(
   parameter int COORD_BITS = LR_COORD_BITS
)(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [COORD_BITS-1:0]    pixel_x,
   input logic [COORD_BITS-1:0]    pixel_y,
   input logic [LR_COLOR_BITS-1:0] out_color,
   input logic                     last_pixel
);

   // Reset empties the output register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // A command transfer closes the request side until the line is done
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request ready right after a command transfer");

   // Within a run, the next pixel follows a transferred pixel at once
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !last_pixel) |=> rsp_valid)
      else $error("gap in a pixel run");

   // A stalled pixel holds its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(pixel_x) && $stable(pixel_y) &&
          $stable(out_color) && $stable(last_pixel)))
      else $error("stalled pixel changed");

endmodule

bind line_rasterizer_top lr_checker #(
   .COORD_BITS (COORD_BITS)
) u_lr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .pixel_x    (rsp_ch.pixel_x),
   .pixel_y    (rsp_ch.pixel_y),
   .out_color  (rsp_ch.out_color),
   .last_pixel (rsp_ch.last_pixel)
);
